### hw/rtl/lnsr_pkg.sv
// Shared types, constants and helpers for the letterbox rectangle scaler.
package lnsr_pkg;

	localparam int COORD_BITS = 16;
	localparam logic [15:0] COORD_MASK = 16'((32'd1 << COORD_BITS) - 32'd1);

	localparam int DIV_STEPS = 16;
	localparam int MID_DEPTH = 4;
	localparam int OUT_DEPTH = 32;
	localparam int NUM_LANES = 4;

	typedef logic [2:0] reg_idx_t;
	localparam reg_idx_t REG_CANVAS_WIDTH  = 3'd0;
	localparam reg_idx_t REG_CANVAS_HEIGHT = 3'd1;
	localparam reg_idx_t REG_LINE_STRIDE   = 3'd2;
	localparam reg_idx_t REG_IMAGE_WIDTH   = 3'd3;
	localparam reg_idx_t REG_IMAGE_HEIGHT  = 3'd4;

	// lane order of the per-item divisions
	localparam int LANE_X0 = 0;
	localparam int LANE_X1 = 1;
	localparam int LANE_Y0 = 2;
	localparam int LANE_Y1 = 3;

	typedef struct packed {
		logic [15:0] src_col;
		logic [15:0] src_row;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
	} in_item_t;

	typedef struct packed {
		logic [15:0] col_start;
		logic [15:0] col_end;
		logic [15:0] row_start;
		logic [15:0] row_end;
		logic [15:0] pixel_color;
		logic [31:0] first_address;
		logic        nothing_drawn;
	} res_item_t;

	// fitted geometry, stable while items flow
	typedef struct packed {
		logic        valid;
		logic [15:0] mw;
		logic [15:0] mh;
		logic [15:0] sw;
		logic [15:0] sh;
		logic [15:0] stride;
		logic [15:0] dw;
		logic [15:0] dh;
		logic [15:0] ox;
		logic [15:0] oy;
	} geo_t;

	typedef struct packed {
		logic                         draw;
		logic [15:0]                  color;
		logic [NUM_LANES-1:0][31:0]   num;
	} mid_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_DIV_H,
		ST_CHECK_H,
		ST_DIV_W,
		ST_CHECK_W,
		ST_FINISH
	} setup_state_t;

	// one restoring step: upper half remainder, lower half dividend bits then quotient
	function automatic logic [31:0] div_step(input logic [31:0] w, input logic [15:0] d);
		logic [16:0] t;
		logic [16:0] diff;
		logic        ge;
		t    = {w[31:16], w[15]};
		diff = t - {1'b0, d};
		ge   = (t >= {1'b0, d});
		div_step = {(ge ? diff[15:0] : t[15:0]), w[14:0], ge};
	endfunction

endpackage

### hw/rtl/lnsr_setup.sv
// Configuration registers and the iterative fit computation.
module lnsr_setup (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  lnsr_pkg::reg_idx_t cfg_index,
	input  logic [15:0]        cfg_data,
	output lnsr_pkg::geo_t     geo,
	output logic               busy
);
	import lnsr_pkg::*;

	setup_state_t state_q, state_d;
	logic [15:0] cw_q, ch_q, stride_q, iw_q, ih_q;
	logic [15:0] mw, mh, sw, sh;
	logic [15:0] rem_q, den_q, dw_q, dh_q, ox_q, oy_q;
	logic [31:0] num_q;
	logic [4:0]  cnt_q;
	logic        valid_q;
	logic        dims_zero, div_run, div_last;
	logic [16:0] t, diff;
	logic        ge;

	assign mw = cw_q & COORD_MASK;
	assign mh = ch_q & COORD_MASK;
	assign sw = iw_q & COORD_MASK;
	assign sh = ih_q & COORD_MASK;
	assign dims_zero = (mw == 16'd0) || (mh == 16'd0) || (sw == 16'd0) || (sh == 16'd0);
	assign div_last  = (cnt_q == 5'd31);

	assign t    = {rem_q, num_q[31]};
	assign diff = t - {1'b0, den_q};
	assign ge   = (t >= {1'b0, den_q});

	always_comb begin
		state_d = state_q;
		if (cfg_we) begin
			state_d = ST_LOAD;
		end else begin
			case (state_q)
				ST_IDLE:    state_d = ST_IDLE;
				ST_LOAD:    state_d = dims_zero ? ST_IDLE : ST_DIV_H;
				ST_DIV_H:   state_d = div_last ? ST_CHECK_H : ST_DIV_H;
				ST_CHECK_H: state_d = (num_q > {16'd0, mh}) ? ST_DIV_W : ST_FINISH;
				ST_DIV_W:   state_d = div_last ? ST_CHECK_W : ST_DIV_W;
				ST_CHECK_W: state_d = ST_FINISH;
				ST_FINISH:  state_d = ST_IDLE;
				default:    state_d = ST_IDLE;
			endcase
		end
	end

	always_comb begin
		busy    = (state_q != ST_IDLE);
		div_run = (state_q == ST_DIV_H) || (state_q == ST_DIV_W);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= 1'b0;
			cw_q <= '0; ch_q <= '0; stride_q <= '0; iw_q <= '0; ih_q <= '0;
			rem_q <= '0; den_q <= '0; num_q <= '0; cnt_q <= '0;
			dw_q <= '0; dh_q <= '0; ox_q <= '0; oy_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				valid_q <= 1'b0;
				case (cfg_index)
					REG_CANVAS_WIDTH:  cw_q     <= cfg_data;
					REG_CANVAS_HEIGHT: ch_q     <= cfg_data;
					REG_LINE_STRIDE:   stride_q <= cfg_data;
					REG_IMAGE_WIDTH:   iw_q     <= cfg_data;
					REG_IMAGE_HEIGHT:  ih_q     <= cfg_data;
					default: ;
				endcase
			end else begin
				if (div_run) begin
					rem_q <= ge ? diff[15:0] : t[15:0];
					num_q <= {num_q[30:0], ge};
					cnt_q <= cnt_q + 5'd1;
				end
				case (state_q)
					ST_LOAD: begin
						rem_q <= '0;
						cnt_q <= '0;
						num_q <= 32'(mw) * 32'(sh);
						den_q <= sw;
					end
					ST_CHECK_H: begin
						if (num_q > {16'd0, mh}) begin
							dh_q  <= mh;
							rem_q <= '0;
							cnt_q <= '0;
							num_q <= 32'(mh) * 32'(sw);
							den_q <= sh;
						end else begin
							dh_q <= (num_q == 32'd0) ? 16'd1 : num_q[15:0];
							dw_q <= mw;
						end
					end
					ST_CHECK_W: begin
						if (num_q == 32'd0)
							dw_q <= 16'd1;
						else if (num_q > {16'd0, mw})
							dw_q <= mw;
						else
							dw_q <= num_q[15:0];
					end
					ST_FINISH: begin
						ox_q    <= (mw - dw_q) >> 1;
						oy_q    <= (mh - dh_q) >> 1;
						valid_q <= 1'b1;
					end
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		geo.valid  = valid_q;
		geo.mw     = mw;
		geo.mh     = mh;
		geo.sw     = sw;
		geo.sh     = sh;
		geo.stride = stride_q;
		geo.dw     = dw_q;
		geo.dh     = dh_q;
		geo.ox     = ox_q;
		geo.oy     = oy_q;
	end

endmodule

### hw/rtl/lnsr_front.sv
// Front end: accepts pixels, classifies them, forms the scaled numerators, short queue.
module lnsr_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  lnsr_pkg::in_item_t src,
	input  lnsr_pkg::geo_t     geo,
	input  logic               busy,
	input  logic               mid_pop,
	output logic               mid_empty,
	output lnsr_pkg::mid_t     mid_head
);
	import lnsr_pkg::*;

	logic        accept;
	logic        valid_s1;
	mid_t        item_s1;
	mid_t        mq_q [MID_DEPTH];
	logic [1:0]  wr_q, rd_q;
	logic [2:0]  cnt_q;
	logic [15:0] sx, sy;

	assign sx = src.src_col & COORD_MASK;
	assign sy = src.src_row & COORD_MASK;

	// room must cover the beat already sitting in s1
	assign full   = busy || ((cnt_q + {2'd0, valid_s1}) >= 3'(MID_DEPTH));
	assign accept = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else
			valid_s1 <= accept;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			// pixels outside the image still map at full width; clipping decides
			item_s1.draw  <= geo.valid;
			item_s1.color <= {src.red[7:3], src.green[7:2], src.blue[7:3]};
			item_s1.num[LANE_X0] <= 32'(sx) * 32'(geo.dw);
			item_s1.num[LANE_X1] <= (32'(sx) + 32'd1) * 32'(geo.dw);
			item_s1.num[LANE_Y0] <= 32'(sy) * 32'(geo.dh);
			item_s1.num[LANE_Y1] <= (32'(sy) + 32'd1) * 32'(geo.dh);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (valid_s1)
				wr_q <= wr_q + 2'd1;
			if (mid_pop)
				rd_q <= rd_q + 2'd1;
			cnt_q <= cnt_q + {2'd0, valid_s1} - {2'd0, mid_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1)
			mq_q[wr_q] <= item_s1;
	end

	assign mid_empty = (cnt_q == 3'd0);
	assign mid_head  = mq_q[rd_q];

endmodule

### hw/rtl/lnsr_back.sv
// Back end: pipelined dividers, offset and clip, address, result queue.
module lnsr_back (
	input  logic                clk,
	input  logic                arst_n,
	input  lnsr_pkg::geo_t      geo,
	input  logic                mid_empty,
	input  lnsr_pkg::mid_t      mid_head,
	output logic                mid_pop,
	input  logic                pop,
	output logic                empty,
	output lnsr_pkg::res_item_t res
);
	import lnsr_pkg::*;

	logic                 vld_q   [DIV_STEPS+1];
	logic                 draw_q  [DIV_STEPS+1];
	logic [15:0]          color_q [DIV_STEPS+1];
	logic [NUM_LANES-1:0] ovf_q   [DIV_STEPS+1];
	logic [31:0]          w_q     [DIV_STEPS+1][NUM_LANES];
	logic [15:0]          den     [NUM_LANES];

	logic [16:0] x0, x1b, x1i, x1, y0, y1b, y1i, y1;
	logic        hit;

	logic        vld_s1, draw_s1;
	logic [15:0] x0_s1, x1_s1, y0_s1, y1_s1, color_s1;
	logic        vld_s2;
	res_item_t   item_s2;
	res_item_t   item_w;
	logic [31:0] prod_s2;

	res_item_t   oq_q [OUT_DEPTH];
	logic [4:0]  wr_q, rd_q;
	logic [5:0]  cnt_q, credit_q;
	logic        out_take;

	assign den[LANE_X0] = geo.sw;
	assign den[LANE_X1] = geo.sw;
	assign den[LANE_Y0] = geo.sh;
	assign den[LANE_Y1] = geo.sh;

	// credit covers every beat in the pipe plus those queued at the output
	assign mid_pop  = !mid_empty && (credit_q < 6'(OUT_DEPTH));
	assign out_take = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= DIV_STEPS; k++)
				vld_q[k] <= 1'b0;
			vld_s1   <= 1'b0;
			vld_s2   <= 1'b0;
			credit_q <= '0;
		end else begin
			vld_q[0] <= mid_pop;
			for (int k = 0; k < DIV_STEPS; k++)
				vld_q[k+1] <= vld_q[k];
			vld_s1   <= vld_q[DIV_STEPS];
			vld_s2   <= vld_s1;
			credit_q <= credit_q + {5'd0, mid_pop} - {5'd0, out_take};
		end
	end

	always_ff @(posedge clk) begin
		draw_q[0]  <= mid_head.draw;
		color_q[0] <= mid_head.color;
		// quotient wider than 16 bits lies past any canvas edge
		for (int l = 0; l < NUM_LANES; l++) begin
			w_q[0][l]   <= mid_head.num[l];
			ovf_q[0][l] <= (mid_head.num[l][31:16] >= den[l]);
		end
		for (int k = 0; k < DIV_STEPS; k++) begin
			draw_q[k+1]  <= draw_q[k];
			color_q[k+1] <= color_q[k];
			ovf_q[k+1]   <= ovf_q[k];
			for (int l = 0; l < NUM_LANES; l++)
				w_q[k+1][l] <= div_step(w_q[k][l], den[l]);
		end
	end

	always_comb begin
		x0  = ovf_q[DIV_STEPS][LANE_X0] ? 17'h1FFFF :
		      {1'b0, geo.ox} + {1'b0, w_q[DIV_STEPS][LANE_X0][15:0]};
		x1b = ovf_q[DIV_STEPS][LANE_X1] ? 17'h1FFFF :
		      {1'b0, geo.ox} + {1'b0, w_q[DIV_STEPS][LANE_X1][15:0]};
		x1i = (x1b <= x0) ? x0 + 17'd1 : x1b;
		x1  = (x1i > {1'b0, geo.mw}) ? {1'b0, geo.mw} : x1i;
		y0  = ovf_q[DIV_STEPS][LANE_Y0] ? 17'h1FFFF :
		      {1'b0, geo.oy} + {1'b0, w_q[DIV_STEPS][LANE_Y0][15:0]};
		y1b = ovf_q[DIV_STEPS][LANE_Y1] ? 17'h1FFFF :
		      {1'b0, geo.oy} + {1'b0, w_q[DIV_STEPS][LANE_Y1][15:0]};
		y1i = (y1b <= y0) ? y0 + 17'd1 : y1b;
		y1  = (y1i > {1'b0, geo.mh}) ? {1'b0, geo.mh} : y1i;
		hit = draw_q[DIV_STEPS] && (x0 < x1) && (y0 < y1);
	end

	always_ff @(posedge clk) begin
		draw_s1  <= hit;
		color_s1 <= color_q[DIV_STEPS];
		x0_s1    <= hit ? x0[15:0] : 16'd0;
		x1_s1    <= hit ? x1[15:0] : 16'd0;
		y0_s1    <= hit ? y0[15:0] : 16'd0;
		y1_s1    <= hit ? y1[15:0] : 16'd0;

		prod_s2                <= 32'(y0_s1) * 32'(geo.stride);
		item_s2.col_start      <= x0_s1;
		item_s2.col_end        <= x1_s1;
		item_s2.row_start      <= y0_s1;
		item_s2.row_end        <= y1_s1;
		item_s2.pixel_color    <= color_s1;
		item_s2.first_address  <= '0;
		item_s2.nothing_drawn  <= !draw_s1;
	end

	always_comb begin
		item_w               = item_s2;
		item_w.first_address = prod_s2 + {16'd0, item_s2.col_start};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (vld_s2)
				wr_q <= wr_q + 5'd1;
			if (out_take)
				rd_q <= rd_q + 5'd1;
			cnt_q <= cnt_q + {5'd0, vld_s2} - {5'd0, out_take};
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s2)
			oq_q[wr_q] <= item_w;
	end

	assign empty = (cnt_q == 6'd0);
	assign res   = oq_q[rd_q];

endmodule

### hw/rtl/letterbox_nearest_scale_rect_unit.sv
// Top level of the letterbox nearest-neighbor rectangle scaler.
//
//  channel   handshake            beat
//  -------   ------------------   -------------------------------------------
//  input     push / full          src  : column, row, RGB888
//  result    pop / empty          res  : clipped rectangle, RGB565, address, flag
//  config    cfg_we               cfg_index selects the register, cfg_data value
//
// One pixel per cycle sustained while full stays low; each pixel passes the front-end
// register, the middle queue, the 16-stage divider pipe, the clip and address registers.
// Each config write starts a refit of up to two 32-step serial divisions; full stays
// high meanwhile. After reset the geometry is empty.
// The 32-entry result queue absorbs pop stalls; full rises when it and the
// 4-entry middle queue fill up.
module letterbox_nearest_scale_rect_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  lnsr_pkg::in_item_t  src,
	input  logic                pop,
	output logic                empty,
	output lnsr_pkg::res_item_t res,
	input  logic                cfg_we,
	input  lnsr_pkg::reg_idx_t  cfg_index,
	input  logic [15:0]         cfg_data
);
	import lnsr_pkg::*;

	geo_t geo;
	logic busy;
	logic mid_pop, mid_empty;
	mid_t mid_head;

	lnsr_setup u_setup (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.geo       (geo),
		.busy      (busy)
	);

	lnsr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.src       (src),
		.geo       (geo),
		.busy      (busy),
		.mid_pop   (mid_pop),
		.mid_empty (mid_empty),
		.mid_head  (mid_head)
	);

	lnsr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.geo       (geo),
		.mid_empty (mid_empty),
		.mid_head  (mid_head),
		.mid_pop   (mid_pop),
		.pop       (pop),
		.empty     (empty),
		.res       (res)
	);

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		mid_pop |-> !mid_empty)
		else $error("middle queue read while empty");

	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> full)
		else $error("input open during refit");

	a_cfg_refit: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> busy && !geo.valid)
		else $error("config write did not start a refit");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && res.nothing_drawn) |-> (res.first_address == 32'd0 &&
		res.col_end == 16'd0 && res.row_end == 16'd0))
		else $error("undrawn beat carries bounds");

endmodule

### bench/letterbox_nearest_scale_rect_unit_tb.sv
// Self-checking bench for the letterbox rectangle scaler: pixel stream in, rectangles out.
`timescale 1ns / 100ps

class rect_scoreboard;
	lnsr_pkg::res_item_t rect_q[$];
	int unsigned errors;
	logic [15:0] cw, ch, stride, iw, ih;

	function new();
		errors = 0;
		cw = '0; ch = '0; stride = '0; iw = '0; ih = '0;
	endfunction

	function void set_reg(lnsr_pkg::reg_idx_t idx, logic [15:0] v);
		case (idx)
			lnsr_pkg::REG_CANVAS_WIDTH: cw = v;
			lnsr_pkg::REG_CANVAS_HEIGHT: ch = v;
			lnsr_pkg::REG_LINE_STRIDE: stride = v;
			lnsr_pkg::REG_IMAGE_WIDTH: iw = v;
			lnsr_pkg::REG_IMAGE_HEIGHT: ih = v;
			default: ;
		endcase
	endfunction

	function lnsr_pkg::res_item_t fit_pixel(lnsr_pkg::in_item_t px);
		lnsr_pkg::res_item_t r;
		longint unsigned dw, dh, ox, oy, x0, x1, y0, y1;
		r = '0;
		r.pixel_color = {px.red[7:3], px.green[7:2], px.blue[7:3]};
		r.nothing_drawn = 1'b1;
		if (iw != 0 && ih != 0 && cw != 0 && ch != 0) begin
			dw = 64'(cw);
			dh = (dw * ih) / iw;
			if (dh > ch) begin
				dh = 64'(ch);
				dw = (dh * iw) / ih;
			end
			if (dw == 0) dw = 1;
			if (dh == 0) dh = 1;
			if (dw > cw) dw = 64'(cw);
			if (dh > ch) dh = 64'(ch);
			ox = (cw - dw) / 2;
			oy = (ch - dh) / 2;
			x0 = ox + (longint'(px.src_col) * dw) / iw;
			x1 = ox + ((longint'(px.src_col) + 1) * dw) / iw;
			if (x1 <= x0) x1 = x0 + 1;
			y0 = oy + (longint'(px.src_row) * dh) / ih;
			y1 = oy + ((longint'(px.src_row) + 1) * dh) / ih;
			if (y1 <= y0) y1 = y0 + 1;
			if (x1 > cw) x1 = 64'(cw);
			if (y1 > ch) y1 = 64'(ch);
			if (x0 < x1 && y0 < y1) begin
				r.nothing_drawn = 1'b0;
				r.col_start = x0[15:0];
				r.col_end = x1[15:0];
				r.row_start = y0[15:0];
				r.row_end = y1[15:0];
				r.first_address = 32'(y0 * stride + x0);
			end
		end
		return r;
	endfunction

	function void note_pixel(lnsr_pkg::in_item_t px);
		rect_q.push_back(fit_pixel(px));
	endfunction

	function void check_rect(lnsr_pkg::res_item_t got);
		lnsr_pkg::res_item_t want;
		if (rect_q.size() == 0) begin
			$error("unexpected result beat %h", got);
			errors++;
			return;
		end
		want = rect_q.pop_front();
		if (got.col_start !== want.col_start) begin
			$error("col_start exp %0d got %0d", want.col_start, got.col_start); errors++;
		end
		if (got.col_end !== want.col_end) begin
			$error("col_end exp %0d got %0d", want.col_end, got.col_end); errors++;
		end
		if (got.row_start !== want.row_start) begin
			$error("row_start exp %0d got %0d", want.row_start, got.row_start); errors++;
		end
		if (got.row_end !== want.row_end) begin
			$error("row_end exp %0d got %0d", want.row_end, got.row_end); errors++;
		end
		if (got.pixel_color !== want.pixel_color) begin
			$error("pixel_color exp %h got %h", want.pixel_color, got.pixel_color); errors++;
		end
		if (got.first_address !== want.first_address) begin
			$error("first_address exp %0d got %0d", want.first_address, got.first_address);
			errors++;
		end
		if (got.nothing_drawn !== want.nothing_drawn) begin
			$error("nothing_drawn exp %b got %b", want.nothing_drawn, got.nothing_drawn);
			errors++;
		end
	endfunction
endclass

module letterbox_nearest_scale_rect_unit_tb;
	import lnsr_pkg::*;

	localparam int WATCHDOG = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	in_item_t src = '0;
	logic pop = 1'b0;
	logic empty;
	res_item_t res;
	logic cfg_we = 1'b0;
	reg_idx_t cfg_index = REG_CANVAS_WIDTH;
	logic [15:0] cfg_data = '0;

	rect_scoreboard sb = new();
	bit calm = 0;       // no random idling on either side
	bit hold_pop = 0;   // long receiver hold-off
	int unsigned idle_cycles = 0;

	letterbox_nearest_scale_rect_unit u_dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// receiver
	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			sb.check_rect(res);
		pop <= !hold_pop && (calm || $urandom_range(99) >= 23);
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic write_reg(reg_idx_t idx, logic [15:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		sb.set_reg(idx, v);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		push <= 1'b0;
		while (sb.rect_q.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic setup(logic [15:0] cw, ch, st, iw, ih);
		drain();
		write_reg(REG_CANVAS_WIDTH, cw);
		write_reg(REG_CANVAS_HEIGHT, ch);
		write_reg(REG_LINE_STRIDE, st);
		write_reg(REG_IMAGE_WIDTH, iw);
		write_reg(REG_IMAGE_HEIGHT, ih);
	endtask

	// push stays high between back-to-back beats; only lowered on an idle cycle
	task automatic send_pixel(in_item_t px);
		while (!calm && $urandom_range(99) < 23) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		src <= px;
		@(posedge clk);
		while (full)
			@(posedge clk);
		sb.note_pixel(px);
	endtask

	function automatic in_item_t rand_pixel(logic [15:0] iw, ih);
		in_item_t p;
		p.red = 8'($urandom);
		p.green = 8'($urandom);
		p.blue = 8'($urandom);
		if ($urandom_range(9) == 0 || iw == 0 || ih == 0) begin
			p.src_col = 16'($urandom);
			p.src_row = 16'($urandom);
		end else begin
			p.src_col = 16'($urandom_range(iw - 1));
			p.src_row = 16'($urandom_range(ih - 1));
		end
		return p;
	endfunction

	task automatic run_phase(logic [15:0] cw, ch, st, iw, ih, int n);
		setup(cw, ch, st, iw, ih);
		repeat (n) send_pixel(rand_pixel(iw, ih));
	endtask

	initial begin
		logic [15:0] a, b, c, d;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero dimensions after reset, then extremes
		send_pixel('{16'd0, 16'd0, 8'hFF, 8'h00, 8'hFF});
		setup(16'd320, 16'd240, 16'd320, 16'd64, 16'd32);
		send_pixel('{16'd0, 16'd0, 8'h00, 8'h00, 8'h00});
		send_pixel('{16'd63, 16'd31, 8'hFF, 8'hFF, 8'hFF});
		send_pixel('{16'd64, 16'd0, 8'h12, 8'h34, 8'h56});
		send_pixel('{16'hFFFF, 16'hFFFF, 8'hA5, 8'h5A, 8'hC3});
		send_pixel('{16'd5, 16'd32, 8'h80, 8'h7F, 8'h01});
		setup(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1, 16'd1);
		send_pixel('{16'd0, 16'd0, 8'hF8, 8'hFC, 8'hF8});
		send_pixel('{16'd1, 16'd0, 8'h07, 8'h03, 8'h07});
		setup(16'd1, 16'd1, 16'd0, 16'hFFFF, 16'hFFFF);
		send_pixel('{16'd0, 16'd0, 8'h11, 8'h22, 8'h33});
		send_pixel('{16'hFFFE, 16'hFFFE, 8'h44, 8'h55, 8'h66});
		setup(16'd100, 16'd0, 16'd100, 16'd10, 16'd10);
		send_pixel('{16'd3, 16'd3, 8'h99, 8'h88, 8'h77});
		setup(16'd640, 16'd100, 16'd16, 16'd0, 16'd10);
		send_pixel('{16'd3, 16'd3, 8'h99, 8'h88, 8'h77});
		setup(16'd40, 16'd300, 16'd10, 16'd1000, 16'd7);  // stride below width, tall canvas
		send_pixel('{16'd999, 16'd6, 8'h01, 8'h02, 8'h03});
		send_pixel('{16'd500, 16'd0, 8'hFE, 8'hFD, 8'hFC});

		// fill-up: receiver holds off while sender keeps offering
		setup(16'd800, 16'd480, 16'd800, 16'd200, 16'd100);
		calm = 1;
		hold_pop = 1;
		fork
			begin
				repeat (300) @(posedge clk);
				hold_pop = 0;
			end
			repeat (120) send_pixel(rand_pixel(16'd200, 16'd100));
		join
		// no-idle stretch
		repeat (150) send_pixel(rand_pixel(16'd200, 16'd100));
		calm = 0;
		drain();  // sender pause until all results are in

		for (int ph = 0; ph < 14; ph++) begin
			a = (ph % 4 == 0) ? 16'($urandom) : 16'($urandom_range(1, 1024));
			b = (ph % 4 == 1) ? 16'($urandom) : 16'($urandom_range(1, 1024));
			c = (ph % 5 == 2) ? 16'($urandom) : 16'($urandom_range(1, 600));
			d = (ph % 5 == 3) ? 16'($urandom) : 16'($urandom_range(1, 600));
			if (ph == 7) c = 16'd0;
			run_phase(a, b, 16'($urandom), c, d, 100);
		end

		drain();
		if (sb.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule

### letterbox_nearest_scale_rect_unit.f
hw/rtl/lnsr_pkg.sv
hw/rtl/lnsr_setup.sv
hw/rtl/lnsr_front.sv
hw/rtl/lnsr_back.sv
hw/rtl/letterbox_nearest_scale_rect_unit.sv
bench/letterbox_nearest_scale_rect_unit_tb.sv
